>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define CHECK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a result on the next edge.
`define CHECK_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

>>> rtl/wle_pkg.sv
`timescale 1ns / 1ps
package wle_pkg;

  localparam logic [3:0] ACT_CLEAR  = 4'd0;
  localparam logic [3:0] ACT_READ   = 4'd1;
  localparam logic [3:0] ACT_WRITE  = 4'd2;
  localparam logic [3:0] ACT_INSERT = 4'd3;
  localparam logic [3:0] ACT_DELETE = 4'd4;
  localparam logic [3:0] ACT_SORT   = 4'd5;
  localparam logic [3:0] ACT_CANON  = 4'd6;
  localparam logic [3:0] ACT_COUNT  = 4'd7;
  localparam logic [3:0] ACT_FIND   = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [6:0]  position;
    logic [63:0] word;
  } wle_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] word_out;
    logic [6:0]  index_or_count;
    logic [6:0]  length;
  } wle_rsp_t;

endpackage

>>> rtl/wle_ram.sv
`timescale 1ns / 1ps
module wle_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/word_list_engine_core.sv
// Word list engine: one command beat at a time, one response beat per command.
// Clear, write and rejected or unknown commands finish in decode; read waits on
// the RAM. Count scans every entry and find stops at its first match. Insert and
// delete shift the entries behind the position; sort is insertion sort, and
// canonicalize drops repeated words, then sorts. The list RAM has a single read
// port. Synchronous reset empties the list; stored words need no clearing.
`timescale 1ns / 1ps
module word_list_engine_core #(
  parameter int DEPTH      = 64,
  parameter int WORD_CHARS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  wle_pkg::wle_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output wle_pkg::wle_rsp_t rsp
);
  import wle_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_READ_W, S_INS_R, S_INS_W, S_DEL_R, S_DEL_W,
    S_SCAN_R, S_SCAN_C, S_SRT_A, S_SRT_V, S_SRT_R, S_SRT_C,
    S_CAN_A, S_CAN_X, S_CAN_R, S_CAN_C, S_DONE
  } state_t;

  function automatic logic [63:0] normalize(input logic [63:0] w);
    logic [63:0] out;
    logic        live;
    out  = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= WORD_CHARS || w[63-8*b -: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        out[63-8*b -: 8] = w[63-8*b -: 8];
      end
    end
    return out;
  endfunction

  state_t      state, state_next;
  logic [3:0]  action;
  logic [6:0]  pos;
  logic [63:0] word;
  logic [CW-1:0] cnt, cnt_next, i, i_next, j, j_next, kept, kept_next;
  logic [63:0] v, v_next;
  logic [1:0]  res_status, res_status_next;
  logic [63:0] res_word, res_word_next;
  logic [6:0]  res_idx, res_idx_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [XW-1:0] pos_x, cnt_x;
  logic          cmd_take, rsp_free;

  assign pos_x     = XW'(pos);
  assign cnt_x     = XW'(cnt);
  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  wle_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    i_next          = i;
    j_next          = j;
    kept_next       = kept;
    v_next          = v;
    res_status_next = res_status;
    res_word_next   = res_word;
    res_idx_next    = res_idx;
    ram_we          = 1'b0;
    ram_waddr       = i[AW-1:0];
    ram_wdata       = word;
    ram_raddr       = i[AW-1:0];
    case (state)
      S_IDLE: begin
        if (cmd_take) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_next = ST_OK;
        res_word_next   = '0;
        res_idx_next    = '0;
        state_next      = S_DONE;
        case (action)
          ACT_CLEAR: cnt_next = '0;
          ACT_READ: begin
            if (pos_x < cnt_x) begin
              ram_raddr  = pos[AW-1:0];
              state_next = S_READ_W;
            end else begin
              res_status_next = ST_BAD_POS;
            end
          end
          ACT_WRITE: begin
            if (pos_x < cnt_x) begin
              ram_we    = 1'b1;
              ram_waddr = pos[AW-1:0];
            end else begin
              res_status_next = ST_BAD_POS;
            end
          end
          ACT_INSERT: begin
            if (pos_x > cnt_x) begin
              res_status_next = ST_BAD_POS;
            end else if (cnt == CW'(DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              i_next     = cnt;
              state_next = S_INS_R;
            end
          end
          ACT_DELETE: begin
            if (pos_x < cnt_x) begin
              cnt_next   = cnt - 1'b1;
              i_next     = CW'(pos);
              state_next = S_DEL_R;
            end else begin
              res_status_next = ST_BAD_POS;
            end
          end
          ACT_SORT: begin
            i_next     = CW'(1);
            state_next = S_SRT_A;
          end
          ACT_CANON: begin
            i_next     = '0;
            kept_next  = '0;
            state_next = S_CAN_A;
          end
          ACT_COUNT, ACT_FIND: begin
            if (action == ACT_FIND) begin
              res_status_next = ST_NOT_FOUND;
            end
            i_next     = '0;
            state_next = S_SCAN_R;
          end
          default: ;
        endcase
      end
      S_READ_W: begin
        res_word_next = ram_rdata;
        state_next    = S_DONE;
      end
      S_INS_R: begin
        if (XW'(i) > pos_x) begin
          ram_raddr  = AW'(i - 1'b1);
          state_next = S_INS_W;
        end else begin
          ram_we     = 1'b1;
          cnt_next   = cnt + 1'b1;
          state_next = S_DONE;
        end
      end
      S_INS_W: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        i_next     = i - 1'b1;
        state_next = S_INS_R;
      end
      S_DEL_R: begin
        if (XW'(i) < cnt_x) begin
          ram_raddr  = AW'(i + 1'b1);
          state_next = S_DEL_W;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DEL_W: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        i_next     = i + 1'b1;
        state_next = S_DEL_R;
      end
      S_SCAN_R: begin
        state_next = (i < cnt) ? S_SCAN_C : S_DONE;
      end
      S_SCAN_C: begin
        i_next     = i + 1'b1;
        state_next = S_SCAN_R;
        if (ram_rdata == word) begin
          if (action == ACT_FIND) begin
            res_idx_next    = 7'(i);
            res_status_next = ST_OK;
            state_next      = S_DONE;
          end else begin
            res_idx_next = res_idx + 1'b1;
          end
        end
      end
      S_SRT_A: begin
        state_next = (i < cnt) ? S_SRT_V : S_DONE;
      end
      S_SRT_V: begin
        v_next     = ram_rdata;
        j_next     = i;
        state_next = S_SRT_R;
      end
      S_SRT_R: begin
        if (j != '0) begin
          ram_raddr  = AW'(j - 1'b1);
          state_next = S_SRT_C;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = j[AW-1:0];
          ram_wdata  = v;
          i_next     = i + 1'b1;
          state_next = S_SRT_A;
        end
      end
      S_SRT_C: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        if (ram_rdata > v) begin
          ram_wdata  = ram_rdata;
          j_next     = j - 1'b1;
          state_next = S_SRT_R;
        end else begin
          ram_wdata  = v;
          i_next     = i + 1'b1;
          state_next = S_SRT_A;
        end
      end
      S_CAN_A: begin
        if (i < cnt) begin
          state_next = S_CAN_X;
        end else begin
          cnt_next   = kept;
          i_next     = CW'(1);
          state_next = S_SRT_A;
        end
      end
      S_CAN_X: begin
        v_next     = ram_rdata;
        j_next     = '0;
        state_next = S_CAN_R;
      end
      S_CAN_R: begin
        if (j < kept) begin
          ram_raddr  = j[AW-1:0];
          state_next = S_CAN_C;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = kept[AW-1:0];
          ram_wdata  = v;
          kept_next  = kept + 1'b1;
          i_next     = i + 1'b1;
          state_next = S_CAN_A;
        end
      end
      S_CAN_C: begin
        if (ram_rdata == v) begin
          i_next     = i + 1'b1;
          state_next = S_CAN_A;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_CAN_R;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid          <= 1'b1;
        rsp.status         <= res_status;
        rsp.word_out       <= res_word;
        rsp.index_or_count <= res_idx;
        rsp.length         <= 7'(cnt);
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (cmd_take) begin
      action <= cmd.action;
      pos    <= cmd.position;
      word   <= normalize(cmd.word);
    end
    i          <= i_next;
    j          <= j_next;
    kept       <= kept_next;
    v          <= v_next;
    res_status <= res_status_next;
    res_word   <= res_word_next;
    res_idx    <= res_idx_next;
  end

`include "assert_macros.svh"

  `CHECK_ALWAYS(a_cnt_range, cnt <= CW'(DEPTH), "entry count above depth")
  `CHECK_ALWAYS(a_no_idle_write, !(state == S_IDLE && ram_we), "RAM write while idle")
  `CHECK_NEXT(a_busy_after_take, cmd_take, state == S_DECODE, "command not decoded")
  `CHECK_NEXT(a_rsp_from_done, !rsp_valid && state != S_DONE, !rsp_valid, "stray response")

endmodule

>>> dv/tb_word_list_engine_core.sv
`timescale 1ns / 1ps
module tb_word_list_engine_core;
  import wle_pkg::*;

  localparam int DEPTH = 64;
  localparam int WORD_CHARS = 8;

  logic     clk;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_stall;
  wle_cmd_t cmd;
  logic     rsp_valid;
  logic     rsp_stall;
  wle_rsp_t rsp;

  word_list_engine_core #(.DEPTH(DEPTH), .WORD_CHARS(WORD_CHARS)) i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  logic [63:0] list_words [DEPTH];
  int          list_len;
  wle_cmd_t    pending_cmds [$];
  wle_rsp_t    expected_rsps [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_send;
  int          errors;
  int          rsp_seen;
  int          op_hits [16];

  function automatic logic [63:0] trim_word(logic [63:0] w);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= WORD_CHARS || w[63-8*b -: 8] == 8'd0) break;
      r[63-8*b -: 8] = w[63-8*b -: 8];
    end
    return r;
  endfunction

  function automatic void sort_words();
    logic [63:0] v;
    int j;
    for (int i = 1; i < list_len; i++) begin
      v = list_words[i];
      j = i;
      while (j > 0 && list_words[j-1] > v) begin
        list_words[j] = list_words[j-1];
        j--;
      end
      list_words[j] = v;
    end
  endfunction

  function automatic wle_rsp_t apply_action(wle_cmd_t c);
    wle_rsp_t    r;
    logic [63:0] w;
    int          p;
    int          kept;
    bit          seen;
    r = '0;
    w = trim_word(c.word);
    p = c.position;
    case (c.action)
      ACT_CLEAR: list_len = 0;
      ACT_READ: begin
        if (p < list_len) r.word_out = list_words[p];
        else r.status = ST_BAD_POS;
      end
      ACT_WRITE: begin
        if (p < list_len) list_words[p] = w;
        else r.status = ST_BAD_POS;
      end
      ACT_INSERT: begin
        if (p > list_len) r.status = ST_BAD_POS;
        else if (list_len >= DEPTH) r.status = ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = w;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (p < list_len) begin
          list_len--;
          for (int i = p; i < list_len; i++) list_words[i] = list_words[i+1];
        end else r.status = ST_BAD_POS;
      end
      ACT_SORT: sort_words();
      ACT_CANON: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          seen = 0;
          for (int k = 0; k < kept; k++)
            if (list_words[k] == list_words[i]) seen = 1;
          if (!seen) begin
            list_words[kept] = list_words[i];
            kept++;
          end
        end
        list_len = kept;
        sort_words();
      end
      ACT_COUNT: begin
        for (int i = 0; i < list_len; i++)
          if (list_words[i] == w) r.index_or_count++;
      end
      ACT_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < list_len; i++)
          if (list_words[i] == w) begin
            r.index_or_count = 7'(i);
            r.status = ST_OK;
            break;
          end
      end
      default: ;
    endcase
    r.length = 7'(list_len);
    return r;
  endfunction

  // small alphabet so duplicates, matches and sort ties are common
  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    int n;
    case ($urandom_range(0, 9))
      0: w = {$urandom, $urandom};
      1: begin
        w = {$urandom, $urandom};
        w[63-8*$urandom_range(0, 7) -: 8] = 8'd0;
      end
      default: begin
        w = '0;
        n = $urandom_range(1, 3);
        for (int b = 0; b < n; b++) w[63-8*b -: 8] = 8'(8'h61 + $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) w[7:0] = 8'($urandom);
      end
    endcase
    return w;
  endfunction

  function automatic wle_cmd_t make_cmd(logic [3:0] a, int p, logic [63:0] w);
    wle_cmd_t c;
    c.action = a;
    c.position = 7'(p);
    c.word = w;
    return c;
  endfunction

  task automatic add_random(int n, int fill_bias);
    logic [3:0] a;
    int p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: a = ACT_CLEAR;
        1, 2: a = ACT_READ;
        3, 4: a = ACT_WRITE;
        5, 6, 7, 8, 9: a = fill_bias ? ACT_INSERT : ACT_DELETE;
        10, 11: a = fill_bias ? ACT_DELETE : ACT_INSERT;
        12: a = ACT_SORT;
        13: a = ACT_CANON;
        14, 15: a = ACT_COUNT;
        16, 17: a = ACT_FIND;
        18: a = 4'($urandom_range(9, 15));
        default: a = ACT_INSERT;
      endcase
      p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 66);
      pending_cmds.push_back(make_cmd(a, p, pick_word()));
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd <= '0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (!hold_send && pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd <= pending_cmds[0];
        op_hits[pending_cmds[0].action]++;
        expected_rsps.push_back(apply_action(pending_cmds.pop_front()));
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    wle_rsp_t e;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp.status);
            errors++;
          end
          if (rsp.word_out !== e.word_out) begin
            $error("word_out: expected %h actual %h", e.word_out, rsp.word_out);
            errors++;
          end
          if (rsp.index_or_count !== e.index_or_count) begin
            $error("index_or_count: expected %0d actual %0d", e.index_or_count,
                   rsp.index_or_count);
            errors++;
          end
          if (rsp.length !== e.length) begin
            $error("length: expected %0d actual %0d", e.length, rsp.length);
            errors++;
          end
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || cmd_valid || expected_rsps.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    cmd_valid = 0;
    cmd = '0;
    rsp_stall = 0;
    hold_send = 0;
    errors = 0;
    rsp_seen = 0;
    list_len = 0;
    send_idle_pct = 8;
    recv_idle_pct = 48;
    for (int i = 0; i < 16; i++) op_hits[i] = 0;
    for (int i = 0; i < DEPTH; i++) list_words[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 0;

    pending_cmds.push_back(make_cmd(ACT_FIND, 0, 64'h6100_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_READ, 0, '0));
    pending_cmds.push_back(make_cmd(ACT_DELETE, 0, '0));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 1, 64'h6100_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 0, '1));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 0, 64'h6200_6363_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 2, 64'h6162_6300_0000_0001));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 1, 64'h6200_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_WRITE, 3, 64'h0000_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_WRITE, 4, 64'h6100_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_READ, 1, '0));
    pending_cmds.push_back(make_cmd(ACT_READ, 127, '0));
    pending_cmds.push_back(make_cmd(ACT_COUNT, 0, 64'h6200_ffff_ffff_ffff));
    pending_cmds.push_back(make_cmd(ACT_FIND, 0, 64'h6162_6300_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_FIND, 0, 64'h7a00_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_SORT, 0, '0));
    pending_cmds.push_back(make_cmd(ACT_CANON, 0, '0));
    pending_cmds.push_back(make_cmd(ACT_DELETE, 0, '0));
    pending_cmds.push_back(make_cmd(4'd15, 127, '1));
    pending_cmds.push_back(make_cmd(ACT_CLEAR, 0, '0));
    for (int i = 0; i < DEPTH; i++)
      pending_cmds.push_back(make_cmd(ACT_INSERT, 0, pick_word()));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 64, 64'h6100_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 65, 64'h6100_0000_0000_0000));
    pending_cmds.push_back(make_cmd(ACT_READ, 63, '0));
    pending_cmds.push_back(make_cmd(ACT_SORT, 0, '0));
    pending_cmds.push_back(make_cmd(ACT_CANON, 0, '0));
    drain();

    // hold the sender while the first random commands are queued, then release it
    hold_send = 1;
    add_random(20, 1);
    repeat (20) @(posedge clk);
    hold_send = 0;
    add_random(330, 1);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 8;
    add_random(330, 0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(330, 1);
    drain();
    repeat (2000) @(posedge clk);

    $display("Covered %0d responses; inserts %0d, deletes %0d, sorts %0d, canonicalizes %0d,",
             rsp_seen, op_hits[ACT_INSERT], op_hits[ACT_DELETE], op_hits[ACT_SORT],
             op_hits[ACT_CANON]);
    $display("finds %0d, counts %0d, under three sender/receiver idling mixes.",
             op_hits[ACT_FIND], op_hits[ACT_COUNT]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wle_pkg.sv
rtl/wle_ram.sv
rtl/word_list_engine_core.sv
dv/tb_word_list_engine_core.sv
